@@ src/pbf_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths and result flag layout for the pixel brightness fade block.
package pbf_pkg;

   localparam int COMP_W   = 8;   // one colour component
   localparam int STEP_W   = 8;   // signed fade step
   localparam int CSR_IDX_W = 2;  // register index width

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_RED   = 2'd0,
      CSR_TARGET_GREEN = 2'd1,
      CSR_TARGET_BLUE  = 2'd2
   } csr_index_type;

   // rsp tuser, lowest bit first: pixel_done, frame_done
   typedef struct packed {
      logic frame_done;
      logic pixel_done;
   } rsp_flags_type;

endpackage

@@ src/pbf_fade.sv @@
`timescale 1ns / 1ps
// One colour component of the fade: dim by scaling or brighten towards target.
module pbf_fade
   import pbf_pkg::*;
(
   input  logic [COMP_W-1:0]        comp_in,
   input  logic signed [STEP_W-1:0] step,
   input  logic [COMP_W-1:0]        target,
   output logic [COMP_W-1:0]        comp_out,
   output logic                     hit
);

   // dimming: factor 256+step equals the raw step bits when step is negative
   logic [2*COMP_W-1:0]   dim_prod;
   logic [COMP_W-1:0]     dim_scaled;
   logic signed [COMP_W+1:0] dim_sum;

   // brightening: step is 0..127 here
   logic [2*COMP_W-2:0]   br_prod;
   logic [COMP_W-2:0]     br_inc;
   logic [COMP_W-2:0]     br_inc_eff;
   logic [COMP_W:0]       br_sum;

   assign dim_prod   = comp_in * $unsigned(step);
   assign dim_scaled = dim_prod[2*COMP_W-1:COMP_W];
   assign dim_sum    = $signed({2'b00, comp_in}) + $signed({{2{step[STEP_W-1]}}, step});

   assign br_prod    = target * step[STEP_W-2:0];
   assign br_inc     = br_prod[2*COMP_W-2:COMP_W];
   assign br_inc_eff = (br_inc == '0) ? (COMP_W-1)'(1) : br_inc;
   assign br_sum     = {1'b0, comp_in} + {2'b00, br_inc_eff};

   always_comb begin
      if (step[STEP_W-1]) begin
         if (dim_scaled == comp_in) begin
            // scaling had no effect: subtract the step magnitude instead
            if (dim_sum <= 0) begin
               comp_out = '0;
               hit      = 1'b1;
            end else begin
               comp_out = dim_sum[COMP_W-1:0];
               hit      = 1'b0;
            end
         end else begin
            comp_out = dim_scaled;
            hit      = (dim_scaled == '0);
         end
      end else begin
         if (br_sum >= {1'b0, target}) begin
            comp_out = target;
            hit      = 1'b1;
         end else begin
            comp_out = br_sum[COMP_W-1:0];
            hit      = 1'b0;
         end
      end
   end

endmodule

@@ src/pixel_brightness_fade.sv @@
`timescale 1ns / 1ps
// Top level of the pixel brightness fade: input register, fade logic, result register.
//
// Usage
//   req channel: one pixel per beat (red, green, blue, signed step) with
//   tlast on the final pixel of a frame. rsp channel: the faded pixel, with
//   tuser carrying pixel_done and frame_done, tlast copied from the request.
//   csr port: write-only target colour (red, green, blue), one register per
//   index; write only while no pixels are in flight.
// Path: a beat accepted on req passes the input register and one pass of the
//   fade logic into the result register, from which it is offered on rsp.
// Throughput: one pixel per cycle unless rsp stalls; each colour component has its
//   own multipliers (8x8 for dimming, 8x7 for brightening), nothing shared.
// Reset: synchronous, active high; empties both stages, clears the targets
//   to black and re-arms the frame-done tracker.
// Stall: while rsp_tready is low the result register holds its beat; the
//   input register still takes one more beat, after which req_tready drops
//   until the result is taken. No beat is dropped or repeated.
// frame_done is the AND of pixel_done over the frame so far and is only
//   reported on the tlast beat; the tracker re-arms after each tlast beat.
module pixel_brightness_fade
   import pbf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,  // red_in, green_in, blue_in, step
   input  logic                 req_tlast,  // last_pixel
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,  // red_out, green_out, blue_out
   output logic [1:0]           rsp_tuser,  // pixel_done, frame_done
   output logic                 rsp_tlast,  // last_out
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COMP_W-1:0]    csr_wdata
);

   // target colour registers
   logic [COMP_W-1:0] tgt_red_ff, tgt_green_ff, tgt_blue_ff;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [31:0]       in_data_ff;
   logic              in_last_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [23:0]       out_data_ff;
   rsp_flags_type     out_flags_ff;
   logic              out_last_ff;

   // frame tracker
   logic              frame_all_done_ff, frame_all_done_in;

   logic              out_free;   // result register can take a beat
   logic              move;       // input register hands its beat on
   logic              take;       // request beat accepted

   logic [COMP_W-1:0] red_fade, green_fade, blue_fade;
   logic              red_hit, green_hit, blue_hit;
   logic              pix_done, acc_done;
   logic signed [STEP_W-1:0] in_step;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign move       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign take       = req_tvalid && req_tready;

   assign in_step = $signed(in_data_ff[31:24]);

   pbf_fade u_fade_red (
      .comp_in  (in_data_ff[7:0]),
      .step     (in_step),
      .target   (tgt_red_ff),
      .comp_out (red_fade),
      .hit      (red_hit)
   );

   pbf_fade u_fade_green (
      .comp_in  (in_data_ff[15:8]),
      .step     (in_step),
      .target   (tgt_green_ff),
      .comp_out (green_fade),
      .hit      (green_hit)
   );

   pbf_fade u_fade_blue (
      .comp_in  (in_data_ff[23:16]),
      .step     (in_step),
      .target   (tgt_blue_ff),
      .comp_out (blue_fade),
      .hit      (blue_hit)
   );

   assign pix_done = red_hit && green_hit && blue_hit;
   assign acc_done = frame_all_done_ff && pix_done;

   always_comb begin
      in_valid_in       = take ? 1'b1 : (move ? 1'b0 : in_valid_ff);
      out_valid_in      = move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      frame_all_done_in = frame_all_done_ff;
      if (move) begin
         frame_all_done_in = in_last_ff ? 1'b1 : acc_done;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         frame_all_done_ff <= 1'b1;
      end else begin
         in_valid_ff       <= in_valid_in;
         out_valid_ff      <= out_valid_in;
         frame_all_done_ff <= frame_all_done_in;
      end
   end

   // targets: reset to black
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_red_ff   <= '0;
         tgt_green_ff <= '0;
         tgt_blue_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_RED:   tgt_red_ff   <= csr_wdata;
            CSR_TARGET_GREEN: tgt_green_ff <= csr_wdata;
            CSR_TARGET_BLUE:  tgt_blue_ff  <= csr_wdata;
            default: ;  // unused index, ignored
         endcase
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (move) begin
         out_data_ff             <= {blue_fade, green_fade, red_fade};
         out_flags_ff.pixel_done <= pix_done;
         out_flags_ff.frame_done <= in_last_ff && acc_done;
         out_last_ff             <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_flags_ff;
   assign rsp_tlast  = out_last_ff;

   // frame_done implies this pixel itself was done
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_flags_ff.frame_done |-> out_flags_ff.pixel_done)
      else $error("frame_done without pixel_done");

   // frame_done only on the last pixel of a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_flags_ff.frame_done |-> rsp_tlast)
      else $error("frame_done on a non-last beat");

   // tracker is re-armed after a last pixel moves on
   assert property (@(posedge clock) disable iff (reset)
      move && in_last_ff |=> frame_all_done_ff)
      else $error("frame tracker not re-armed after last pixel");

   // a stalled input stage keeps its beat
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register lost a beat under stall");

   // a beat moving on always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      move |=> out_valid_ff)
      else $error("result register missed a beat");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pixel_brightness_fade: random frames against a fade scoreboard.
module testbench;
   import pbf_pkg::*;

   localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the block

   // one request beat as the sender sees it
   typedef struct {
      logic [COMP_W-1:0]        red;
      logic [COMP_W-1:0]        green;
      logic [COMP_W-1:0]        blue;
      logic signed [STEP_W-1:0] step;
      logic                     last;
   } pixel_beat_type;

   // one result beat, field by field
   typedef struct {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic              pixel_done;
      logic              frame_done;
      logic              last;
   } faded_beat_type;

   // Scoreboard: keeps its own copy of the targets and the frame tracker,
   // works out each faded pixel on acceptance and checks results in order.
   class fade_checker;
      logic [COMP_W-1:0] target [3] = '{default: '0};
      bit                frame_all_ok = 1'b1;
      faded_beat_type    expected_pixels [$];
      int                errors = 0;
      int                pixels_checked = 0;
      int                frames_checked = 0;
      int                done_pixels = 0;
      int                done_frames = 0;

      function void set_target(csr_index_type idx, logic [COMP_W-1:0] value);
         target[idx] = value;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // one component: dim by (256+step)/256 or brighten toward the bound
      function logic [COMP_W-1:0] fade_component(input logic [COMP_W-1:0] comp,
                                                 input logic signed [STEP_W-1:0] step,
                                                 input logic [COMP_W-1:0] bound,
                                                 output bit at_bound);
         int level, s, scaled, rise;
         level = int'(comp);
         s = int'(step);
         if (s < 0) begin
            scaled = level * (256 + s) / 256;
            // only a black component survives scaling, then the step is added
            level = (scaled == level) ? level + s : scaled;
            at_bound = (level <= 0);
            if (at_bound) level = 0;
         end else begin
            rise = int'(bound) * s / 256;
            if (rise == 0) rise = 1;
            level += rise;
            at_bound = (level >= int'(bound));
            if (at_bound) level = int'(bound);
         end
         return level[COMP_W-1:0];
      endfunction

      function void note_pixel(pixel_beat_type px);
         faded_beat_type want;
         bit hit_r, hit_g, hit_b;
         want.red   = fade_component(px.red,   px.step, target[CSR_TARGET_RED],   hit_r);
         want.green = fade_component(px.green, px.step, target[CSR_TARGET_GREEN], hit_g);
         want.blue  = fade_component(px.blue,  px.step, target[CSR_TARGET_BLUE],  hit_b);
         want.pixel_done = hit_r && hit_g && hit_b;
         frame_all_ok = frame_all_ok & want.pixel_done;
         want.frame_done = px.last ? frame_all_ok : 1'b0;
         want.last = px.last;
         if (px.last) frame_all_ok = 1'b1;
         expected_pixels.push_back(want);
      endfunction

      function void check_pixel(logic [3*COMP_W-1:0] data, rsp_flags_type flags,
                                logic last);
         faded_beat_type want, got;
         got.red        = data[COMP_W-1:0];
         got.green      = data[2*COMP_W-1:COMP_W];
         got.blue       = data[3*COMP_W-1:2*COMP_W];
         got.pixel_done = flags.pixel_done;
         got.frame_done = flags.frame_done;
         got.last       = last;
         pixels_checked++;
         done_pixels += (got.pixel_done === 1'b1);
         frames_checked += (got.last === 1'b1);
         done_frames += (got.frame_done === 1'b1);
         if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("beat %0d unexpected: rgb %h %h %h pd %b fd %b last %b",
                        pixels_checked, got.red, got.green, got.blue,
                        got.pixel_done, got.frame_done, got.last);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
             got.pixel_done !== want.pixel_done || got.frame_done !== want.frame_done ||
             got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
               $display("beat %0d expected: rgb %h %h %h pd %b fd %b last %b",
                        pixels_checked, want.red, want.green, want.blue,
                        want.pixel_done, want.frame_done, want.last);
               $display("beat %0d got:      rgb %h %h %h pd %b fd %b last %b",
                        pixels_checked, got.red, got.green, got.blue,
                        got.pixel_done, got.frame_done, got.last);
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [31:0]         req_tdata;   // red_in, green_in, blue_in, step
   logic                req_tlast;   // last_pixel
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;   // red_out, green_out, blue_out
   logic [1:0]          rsp_tuser;   // pixel_done, frame_done
   logic                rsp_tlast;   // last_out
   logic                csr_we;
   csr_index_type       csr_index;
   logic [COMP_W-1:0]   csr_wdata;

   fade_checker sb;
   int send_idle_pct = 0;   // sender gap odds per cycle, main process only
   int rsp_stall_pct = 0;   // receiver stall odds per cycle, written with <=
   int hold_token = 0;      // bumped by the main process to ask for a hold-off
   int hold_seen = 0;
   int hold_left = 0;

   pixel_brightness_fade uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver: checks every accepted result beat and decides rsp_tready for
   // the next edge. A hold-off request from the main process is counted down
   // here so that it runs on while the sender keeps offering pixels.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_pixel(rsp_tdata, rsp_tuser, rsp_tlast);
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one pixel, wait for the handshake, then maybe leave a gap.
   // On the fast path valid stays high and the next call just swaps the data.
   task automatic send_pixel(input pixel_beat_type px);
      req_tdata  <= {px.step, px.blue, px.green, px.red};
      req_tlast  <= px.last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pixel(px);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_rgb(input logic [7:0] r, g, b, input logic signed [7:0] step,
                           input logic last);
      pixel_beat_type px;
      px.red = r;
      px.green = g;
      px.blue = b;
      px.step = step;
      px.last = last;
      send_pixel(px);
   endtask

   // csr_we is left high between back-to-back writes, lowered by the caller
   task automatic write_csr(input csr_index_type idx, input logic [COMP_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_target(idx, value);
   endtask

   task automatic write_targets(input logic [7:0] r, g, b);
      write_csr(CSR_TARGET_RED, r);
      write_csr(CSR_TARGET_GREEN, g);
      write_csr(CSR_TARGET_BLUE, b);
      csr_we <= 1'b0;
   endtask

   // stop offering and wait until every expected pixel is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Mostly uniform fields. A settled frame pushes every component onto its
   // bound (near black when dimming, at or above target when brightening)
   // so that done pixels and done frames turn up often.
   function automatic pixel_beat_type random_pixel(input bit settled, input bit last);
      pixel_beat_type px;
      px.red   = COMP_W'($urandom_range(255));
      px.green = COMP_W'($urandom_range(255));
      px.blue  = COMP_W'($urandom_range(255));
      px.step  = STEP_W'($urandom_range(255));
      px.last  = last;
      if (settled) begin
         if ($urandom_range(1)) begin
            px.step  = STEP_W'(-$urandom_range(128, 1));
            px.red   = COMP_W'($urandom_range(1));
            px.green = COMP_W'($urandom_range(1));
            px.blue  = COMP_W'($urandom_range(1));
         end else begin
            px.step  = STEP_W'($urandom_range(127));
            px.red   = COMP_W'($urandom_range(255, sb.target[CSR_TARGET_RED]));
            px.green = COMP_W'($urandom_range(255, sb.target[CSR_TARGET_GREEN]));
            px.blue  = COMP_W'($urandom_range(255, sb.target[CSR_TARGET_BLUE]));
         end
      end
      return px;
   endfunction

   // whole frames of 1..8 pixels until the count is used up
   task automatic send_frames(input int pixel_count);
      int left, len;
      bit settled;
      left = pixel_count;
      while (left > 0) begin
         len = $urandom_range(8, 1);
         if (len > left) len = left;
         settled = ($urandom_range(99) < 35);
         for (int i = 0; i < len; i++)
            send_pixel(random_pixel(settled, i == len - 1));
         left -= len;
      end
   endtask

   // one setting of targets and idling; starts and ends with the block empty
   task automatic run_phase(input logic [7:0] r, g, b, input int idle_pct, stall_pct,
                            input bit hold_off, input int pixel_count);
      write_targets(r, g, b);
      send_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      if (hold_off) hold_token <= hold_token + 1;
      send_frames(pixel_count);
      drain();
   endtask

   initial begin
      sb = new;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_TARGET_RED;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: full, half and zero target so every bound kind is hit
      write_targets(8'd255, 8'd128, 8'd0);
      send_rgb(8'd0,   8'd0,   8'd0,   -8'sd1,   1'b0);  // black dimmed, stays at bound
      send_rgb(8'd255, 8'd255, 8'd255, -8'sd128, 1'b0);  // deepest dim on white
      send_rgb(8'd1,   8'd1,   8'd1,   -8'sd128, 1'b0);  // dims to black
      send_rgb(8'd255, 8'd1,   8'd0,   -8'sd1,   1'b0);  // smallest dim
      send_rgb(8'd255, 8'd128, 8'd0,   8'sd0,    1'b0);  // zero step, already at target
      send_rgb(8'd10,  8'd20,  8'd30,  8'sd0,    1'b0);  // zero step adds one; blue clamps to its zero target
      send_rgb(8'd0,   8'd0,   8'd0,   8'sd127,  1'b0);  // largest brighten from black
      send_rgb(8'd127, 8'd127, 8'd127, 8'sd1,    1'b0);  // tiny step, minimum increment
      send_rgb(8'd255, 8'd255, 8'd255, 8'sd127,  1'b1);  // above target: clamped down
      // frame where every pixel is done
      send_rgb(8'd0,   8'd0,   8'd0,   -8'sd5,   1'b0);
      send_rgb(8'd1,   8'd0,   8'd1,   -8'sd128, 1'b0);
      send_rgb(8'd255, 8'd200, 8'd7,   8'sd100,  1'b1);
      // frame with one pixel short of its bound
      send_rgb(8'd0,   8'd0,   8'd0,   -8'sd1,   1'b0);
      send_rgb(8'd50,  8'd50,  8'd50,  -8'sd1,   1'b0);
      send_rgb(8'd0,   8'd0,   8'd0,   -8'sd1,   1'b1);
      // single-pixel frames, done and not done
      send_rgb(8'd0,   8'd0,   8'd0,   -8'sd128, 1'b1);
      send_rgb(8'd128, 8'd128, 8'd128, -8'sd64,  1'b1);
      // sender pause: nothing more until the block has emptied
      drain();

      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                0, 0, 1'b0, 250);
      run_phase(8'd0, 8'd0, 8'd0, 47, 0, 1'b0, 250);
      run_phase(8'd255, 8'd255, 8'd255, 0, 47, 1'b0, 250);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                15, 15, 1'b0, 250);
      // long receiver hold-off with the sender pressing on: input side stalls
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                0, 0, 1'b1, 250);

      repeat (4) @(posedge clock);
      $display("checked %0d pixels in %0d frames over six target settings",
               sb.pixels_checked, sb.frames_checked);
      $display("%0d pixels and %0d frames reached their bounds; %0d mismatches",
               sb.done_pixels, sb.done_frames, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
